FILE: sv/fbmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbmc_pkg
// Shared types, register map, mode table and geometry helpers for the
// framebuffer mode control register block.
// ----------------------------------------------------------------------------
package fbmc_pkg;

   localparam int PALETTE_SIZE_DEF    = 256;
   localparam int MODE_TABLE_SIZE_DEF = 8;
   localparam int MODE_TABLE_MAX      = 8;
   localparam int MODE_IDX_W          = 3;
   localparam int PAL_W               = 24;
   localparam int CSR_IDX_W           = 3;

   localparam logic [31:0] ID_WORD      = 32'h4642_5546;
   localparam logic [31:0] VERSION_WORD = 32'd1;
   localparam logic [2:0]  ACC_WORD     = 3'd4;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_LOAD  = 2'd1;
   localparam logic [1:0] FAULT_STORE = 2'd2;

   localparam logic [11:0] REG_ID          = 12'h000;
   localparam logic [11:0] REG_VERSION     = 12'h004;
   localparam logic [11:0] REG_WIDTH       = 12'h008;
   localparam logic [11:0] REG_HEIGHT      = 12'h00C;
   localparam logic [11:0] REG_FORMAT      = 12'h010;
   localparam logic [11:0] REG_STRIDE      = 12'h014;
   localparam logic [11:0] REG_BASE        = 12'h018;
   localparam logic [11:0] REG_BYTES       = 12'h01C;
   localparam logic [11:0] REG_FLUSH       = 12'h020;
   localparam logic [11:0] REG_FRAMES      = 12'h024;
   localparam logic [11:0] REG_MODE_COUNT  = 12'h028;
   localparam logic [11:0] REG_MODE_NUMBER = 12'h02C;
   localparam logic [11:0] REG_MODE_WIDTH  = 12'h030;
   localparam logic [11:0] REG_MODE_HEIGHT = 12'h034;
   localparam logic [11:0] REG_MODE_FORMAT = 12'h038;
   localparam logic [11:0] REG_MODE_INDEX  = 12'h03C;
   localparam logic [11:0] REG_MODE_SET    = 12'h040;
   localparam logic [11:0] REG_MODE_OK     = 12'h044;
   localparam logic [1:0]  PAL_WINDOW      = 2'b01;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_BYTES   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_WIDTH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_HEIGHT    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_FORMAT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_STRIDE    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENT_ENABLE = 3'd6;

   localparam logic [15:0] MODE_NUM    [MODE_TABLE_MAX] = '{
      16'h013, 16'h100, 16'h101, 16'h103, 16'h105, 16'h112, 16'h115, 16'h118};
   localparam logic [15:0] MODE_WIDTH  [MODE_TABLE_MAX] = '{
      16'd320, 16'd640, 16'd640, 16'd800, 16'd1024, 16'd640, 16'd800, 16'd1024};
   localparam logic [15:0] MODE_HEIGHT [MODE_TABLE_MAX] = '{
      16'd200, 16'd400, 16'd480, 16'd600, 16'd768, 16'd480, 16'd600, 16'd768};
   localparam logic        MODE_FMT    [MODE_TABLE_MAX] = '{
      1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};
   // natural stride times height
   localparam logic [31:0] MODE_BYTES  [MODE_TABLE_MAX] = '{
      32'd64000, 32'd256000, 32'd307200, 32'd480000,
      32'd786432, 32'd1228800, 32'd1920000, 32'd3145728};

   typedef struct packed {
      logic        command;
      logic [11:0] reg_offset;
      logic [2:0]  access_size;
      logic [31:0] write_data;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [1:0]  fault;
      logic        present_pulse;
   } rsp_type;

   typedef struct packed {
      logic [15:0] width;
      logic [15:0] height;
      logic        format;
      logic [19:0] stride;
   } geom_init_type;

   typedef struct packed {
      logic [15:0] width;
      logic [15:0] height;
      logic        format;
      logic [19:0] stride;
      logic [15:0] mode_id;
   } geom_type;

   typedef struct packed {
      logic          load;
      geom_init_type init;
   } geom_load_type;

   typedef struct packed {
      logic        set_en;
      logic [31:0] number;
   } mode_cmd_type;

   localparam geom_init_type INIT_RESET = '{
      width: 16'd320, height: 16'd200, format: 1'b0, stride: 20'd0};

   function automatic logic [19:0] natural_stride(logic [15:0] width, logic format);
      return format ? {2'b00, width, 2'b00} : {4'b0000, width};
   endfunction

   function automatic geom_type geom_from_init(geom_init_type ini, int tbl_size);
      geom_type g;
      g.width       = ini.width;
      g.height      = ini.height;
      g.format      = ini.format;
      g.stride      = (ini.stride == 20'd0) ? natural_stride(ini.width, ini.format)
                                            : ini.stride;
      g.mode_id     = '0;
      // descending so the first matching entry wins
      for (int i = MODE_TABLE_MAX - 1; i >= 0; i--) begin
         if (i < tbl_size && MODE_WIDTH[i] == ini.width &&
             MODE_HEIGHT[i] == ini.height && MODE_FMT[i] == ini.format) begin
            g.mode_id = MODE_NUM[i];
         end
      end
      return g;
   endfunction

endpackage
`default_nettype wire

FILE: sv/fbmc_palette.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbmc_palette
// Palette store: synchronous memory with registered read data and a
// valid bit per entry; unwritten entries read as the greyscale ramp.
// ----------------------------------------------------------------------------
module fbmc_palette #(
   parameter int PALETTE_SIZE = fbmc_pkg::PALETTE_SIZE_DEF,
   parameter int ADDR_W       = $clog2(PALETTE_SIZE)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       wr_en,
   input  wire logic                       rd_en,
   input  wire logic [ADDR_W-1:0]          addr,
   input  wire logic [fbmc_pkg::PAL_W-1:0] wr_data,
   output logic      [fbmc_pkg::PAL_W-1:0] rd_data
);
   import fbmc_pkg::*;

   logic [PAL_W-1:0]        mem_ff [PALETTE_SIZE];
   logic [PALETTE_SIZE-1:0] vld_ff;
   logic [PALETTE_SIZE-1:0] vld_in;
   logic [PAL_W-1:0]        rd_data_ff;
   logic                    rd_vld_ff;
   logic [ADDR_W-1:0]       rd_addr_ff;
   logic [7:0]              ramp;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
         rd_vld_ff  <= vld_ff[addr];
         rd_addr_ff <= addr;
      end
   end

   assign ramp    = 8'(rd_addr_ff);
   assign rd_data = rd_vld_ff ? rd_data_ff : {ramp, ramp, ramp};

   a_write_marks_valid: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vld_ff[$past(addr)])
      else $error("palette entry not marked valid after write");

endmodule
`default_nettype wire

FILE: sv/fbmc_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbmc_geom
// Current geometry, mode number and mode-set outcome; reloads from the
// initial registers and applies mode changes that fit the buffer.
// ----------------------------------------------------------------------------
module fbmc_geom #(
   parameter int MODE_TABLE_SIZE = fbmc_pkg::MODE_TABLE_SIZE_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire fbmc_pkg::geom_load_type geom_load,
   input  wire fbmc_pkg::mode_cmd_type  mode_cmd,
   input  wire logic [31:0]             buffer_bytes,
   output fbmc_pkg::geom_type           geom,
   output logic                         set_ok
);
   import fbmc_pkg::*;

   geom_type geom_ff;
   geom_type geom_in;
   logic     set_ok_ff;
   logic     set_ok_in;
   geom_type set_geom;
   logic     set_found;
   logic     set_fits;

   always_comb begin
      set_found = 1'b0;
      set_fits  = 1'b0;
      set_geom  = geom_ff;
      for (int i = MODE_TABLE_MAX - 1; i >= 0; i--) begin
         if (i < MODE_TABLE_SIZE && mode_cmd.number == 32'(MODE_NUM[i])) begin
            set_found        = 1'b1;
            set_fits         = MODE_BYTES[i] <= buffer_bytes;
            set_geom.width   = MODE_WIDTH[i];
            set_geom.height  = MODE_HEIGHT[i];
            set_geom.format  = MODE_FMT[i];
            set_geom.stride  = natural_stride(MODE_WIDTH[i], MODE_FMT[i]);
            set_geom.mode_id = MODE_NUM[i];
         end
      end
   end

   always_comb begin
      geom_in   = geom_ff;
      set_ok_in = set_ok_ff;
      if (geom_load.load) begin
         geom_in = geom_from_init(geom_load.init, MODE_TABLE_SIZE);
      end else if (mode_cmd.set_en) begin
         set_ok_in = set_found && set_fits;
         if (set_found && set_fits) begin
            geom_in = set_geom;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff   <= geom_from_init(INIT_RESET, MODE_TABLE_SIZE);
         set_ok_ff <= 1'b1;
      end else begin
         geom_ff   <= geom_in;
         set_ok_ff <= set_ok_in;
      end
   end

   assign geom   = geom_ff;
   assign set_ok = set_ok_ff;

endmodule
`default_nettype wire

FILE: sv/framebuffer_mode_control_regs_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framebuffer_mode_control_regs_unit
// Framebuffer control register block: ID, geometry, frame counter, mode
// table access, mode set and a 24-bit palette.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  fbmc_pkg::req_type
//   rsp_     out  rsp_valid/rsp_stall  fbmc_pkg::rsp_type
//   csr_     in   csr_we               csr_idx, csr_wdata
//
// One item per cycle unless rsp_stall holds a valid result; each result
// comes in the cycle after its item is taken (palette read is registered).
// The output register takes a new item in the cycle its result is taken.
// On reset, palette entries come up as the greyscale ramp via
// per-entry valid bits, so no clearing pass.
// ----------------------------------------------------------------------------
module framebuffer_mode_control_regs_unit #(
   parameter int PALETTE_SIZE    = fbmc_pkg::PALETTE_SIZE_DEF,
   parameter int MODE_TABLE_SIZE = fbmc_pkg::MODE_TABLE_SIZE_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire fbmc_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output fbmc_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_we,
   input  wire logic [fbmc_pkg::CSR_IDX_W-1:0]   csr_idx,
   input  wire logic [31:0]                      csr_wdata
);
   import fbmc_pkg::*;

   localparam int PAL_AW = $clog2(PALETTE_SIZE);

   logic [31:0]           buffer_base_ff;
   logic [31:0]           buffer_bytes_ff;
   geom_init_type         init_ff;
   geom_init_type         init_in;
   logic                  present_en_ff;
   logic [31:0]           frame_count_ff;
   logic [31:0]           frame_count_in;
   logic [MODE_IDX_W-1:0] enum_index_ff;
   logic [MODE_IDX_W-1:0] enum_index_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [31:0]           rsp_rd_ff;
   logic [31:0]           rsp_rd_in;
   logic [1:0]            rsp_fault_ff;
   logic [1:0]            rsp_fault_in;
   logic                  rsp_pulse_ff;
   logic                  rsp_pulse_in;
   logic                  rsp_pal_ff;
   logic                  rsp_pal_in;

   logic                  req_acc;
   logic                  bad_access;
   logic                  in_pal;
   logic                  rd_ok;
   logic                  wr_ok;
   logic                  flush_wr;
   logic                  pal_we;
   logic                  pal_re;
   logic [PAL_AW-1:0]     pal_addr;
   logic [PAL_W-1:0]      pal_rd_data;
   logic [31:0]           reg_rd;
   geom_load_type         geom_load;
   mode_cmd_type          mode_cmd;
   geom_type              geom;
   logic                  set_ok;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_acc   = req_valid && !req_stall;

   // decode
   assign bad_access = (req_data.access_size != ACC_WORD) ||
                       (req_data.reg_offset[1:0] != 2'b00);
   assign in_pal     = (req_data.reg_offset[11:10] == PAL_WINDOW) &&
                       ({1'b0, req_data.reg_offset[9:2]} < 9'(PALETTE_SIZE));
   assign rd_ok      = req_acc && !bad_access && (req_data.command == CMD_READ);
   assign wr_ok      = req_acc && !bad_access && (req_data.command == CMD_WRITE);
   assign flush_wr   = wr_ok && !in_pal && (req_data.reg_offset == REG_FLUSH);
   assign pal_we     = wr_ok && in_pal;
   assign pal_re     = rd_ok && in_pal;
   assign pal_addr   = req_data.reg_offset[2 +: PAL_AW];

   assign mode_cmd.set_en = wr_ok && !in_pal && (req_data.reg_offset == REG_MODE_SET);
   assign mode_cmd.number = req_data.write_data;

   always_comb begin
      unique case (req_data.reg_offset)
         REG_ID:          reg_rd = ID_WORD;
         REG_VERSION:     reg_rd = VERSION_WORD;
         REG_WIDTH:       reg_rd = 32'(geom.width);
         REG_HEIGHT:      reg_rd = 32'(geom.height);
         REG_FORMAT:      reg_rd = 32'(geom.format);
         REG_STRIDE:      reg_rd = 32'(geom.stride);
         REG_BASE:        reg_rd = buffer_base_ff;
         REG_BYTES:       reg_rd = buffer_bytes_ff;
         REG_FRAMES:      reg_rd = frame_count_ff;
         REG_MODE_COUNT:  reg_rd = 32'(MODE_TABLE_SIZE);
         REG_MODE_NUMBER: reg_rd = 32'(MODE_NUM[enum_index_ff]);
         REG_MODE_WIDTH:  reg_rd = 32'(MODE_WIDTH[enum_index_ff]);
         REG_MODE_HEIGHT: reg_rd = 32'(MODE_HEIGHT[enum_index_ff]);
         REG_MODE_FORMAT: reg_rd = 32'(MODE_FMT[enum_index_ff]);
         REG_MODE_INDEX:  reg_rd = 32'(enum_index_ff);
         REG_MODE_SET:    reg_rd = 32'(geom.mode_id);
         REG_MODE_OK:     reg_rd = 32'(set_ok);
         default:         reg_rd = '0;
      endcase
   end

   // item state
   always_comb begin
      frame_count_in = frame_count_ff;
      enum_index_in  = enum_index_ff;
      if (flush_wr) begin
         frame_count_in = frame_count_ff + 32'd1;
      end
      if (wr_ok && !in_pal && req_data.reg_offset == REG_MODE_INDEX) begin
         enum_index_in = (req_data.write_data < 32'(MODE_TABLE_SIZE))
                         ? req_data.write_data[MODE_IDX_W-1:0]
                         : MODE_IDX_W'(MODE_TABLE_SIZE - 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= '0;
         enum_index_ff  <= '0;
      end else begin
         frame_count_ff <= frame_count_in;
         enum_index_ff  <= enum_index_in;
      end
   end

   // configuration
   always_comb begin
      init_in = init_ff;
      unique case (csr_idx)
         CSR_INIT_WIDTH:  init_in.width  = csr_wdata[15:0];
         CSR_INIT_HEIGHT: init_in.height = csr_wdata[15:0];
         CSR_INIT_FORMAT: init_in.format = csr_wdata[0];
         CSR_INIT_STRIDE: init_in.stride = csr_wdata[19:0];
         default: ;
      endcase
   end

   assign geom_load.load = csr_we && (csr_idx inside {CSR_INIT_WIDTH, CSR_INIT_HEIGHT,
                                                      CSR_INIT_FORMAT, CSR_INIT_STRIDE});
   assign geom_load.init = init_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_base_ff  <= '0;
         buffer_bytes_ff <= 32'd64000;
         init_ff         <= INIT_RESET;
         present_en_ff   <= 1'b0;
      end else if (csr_we) begin
         if (csr_idx == CSR_BUFFER_BASE) begin
            buffer_base_ff <= csr_wdata;
         end
         if (csr_idx == CSR_BUFFER_BYTES) begin
            buffer_bytes_ff <= csr_wdata;
         end
         if (csr_idx == CSR_PRESENT_ENABLE) begin
            present_en_ff <= csr_wdata[0];
         end
         init_ff <= init_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = req_acc || (rsp_valid_ff && rsp_stall);
      rsp_rd_in    = (rd_ok && !in_pal) ? reg_rd : '0;
      rsp_pal_in   = pal_re;
      rsp_pulse_in = flush_wr && present_en_ff;
      rsp_fault_in = FAULT_NONE;
      if (bad_access) begin
         rsp_fault_in = (req_data.command == CMD_WRITE) ? FAULT_STORE : FAULT_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_rd_ff    <= rsp_rd_in;
         rsp_fault_ff <= rsp_fault_in;
         rsp_pulse_ff <= rsp_pulse_in;
         rsp_pal_ff   <= rsp_pal_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data.read_data     = rsp_pal_ff ? 32'(pal_rd_data) : rsp_rd_ff;
   assign rsp_data.fault         = rsp_fault_ff;
   assign rsp_data.present_pulse = rsp_pulse_ff;

   fbmc_palette #(
      .PALETTE_SIZE (PALETTE_SIZE),
      .ADDR_W       (PAL_AW)
   ) u_palette (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (pal_we),
      .rd_en   (pal_re),
      .addr    (pal_addr),
      .wr_data (req_data.write_data[PAL_W-1:0]),
      .rd_data (pal_rd_data)
   );

   fbmc_geom #(
      .MODE_TABLE_SIZE (MODE_TABLE_SIZE)
   ) u_geom (
      .clock        (clock),
      .reset        (reset),
      .geom_load    (geom_load),
      .mode_cmd     (mode_cmd),
      .buffer_bytes (buffer_bytes_ff),
      .geom         (geom),
      .set_ok       (set_ok)
   );

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> rsp_valid_ff)
      else $error("accepted item produced no result");

   a_flush_counts: assert property (@(posedge clock) disable iff (reset)
      flush_wr |=> frame_count_ff == $past(frame_count_ff) + 32'd1)
      else $error("frame counter did not advance on flush");

   a_width_reload: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_idx == CSR_INIT_WIDTH) |=> geom.width == $past(csr_wdata[15:0]))
      else $error("geometry width not reloaded from configuration");

endmodule
`default_nettype wire
